FILE: design/cbrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbrf_pkg
// shared widths, constants, status codes and the types that link the
// bisection sequencer to the polynomial evaluation unit
// ----------------------------------------------------------------------------
package cbrf_pkg;

	// Q16.16 operand width and unsigned Q15.16 tolerance width
	localparam int XW    = 32;
	localparam int TOL_W = 31;

	// f(x) * 2^48 held exactly; |x^3| < 2^94 so 96 bits cover the whole range
	localparam int FW = 96;

	// step limit and step counter width
	localparam int MAX_STEPS = 64;
	localparam int STEP_W    = 7;

	// status codes
	localparam logic [1:0] STATUS_CONVERGED = 2'd0;
	localparam logic [1:0] STATUS_SAME_SIGN = 2'd1;
	localparam logic [1:0] STATUS_STEP_CAP  = 2'd2;

	// 1 - 9 * 2^48: carry-in of the negation folded with the constant term
	localparam logic [FW-1:0] OFF_K = FW'(1) - (FW'(9) << 48);

	// request into the evaluation unit
	typedef struct packed {
		logic                 go;
		logic signed [XW-1:0] x;
	} feval_req_t;

	// response from the evaluation unit
	typedef struct packed {
		logic                 done;
		logic signed [FW-1:0] f;
	} feval_rsp_t;

endpackage
`default_nettype wire

FILE: design/cubic_bisection_root_finder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cubic_bisection_root_finder_top
// bisection search for a root of x^3 - 4x - 9 over a Q16.16 bracket
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy then stays high
// until the result has been shown. Each word gives exactly one result, shown
// for a single cycle with done high; the receiver must take it in that cycle,
// there is no way to hold it off. Every polynomial value comes from one shared
// 32x32 multiplier; each evaluation steps through a square, two partial
// products and two wide adds plus handoff. Both guesses are checked first;
// each bisection step then takes a midpoint, an evaluation and a tolerance
// test, with at most 64 steps per word. A bracket whose ends give the same
// strict sign returns after the check of both guesses with status 1.
// ----------------------------------------------------------------------------
module cubic_bisection_root_finder_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output      logic                               busy,
	input  wire logic signed [cbrf_pkg::XW-1:0]     first_guess,
	input  wire logic signed [cbrf_pkg::XW-1:0]     second_guess,
	input  wire logic        [cbrf_pkg::TOL_W-1:0]  tolerance,
	output      logic                               done,
	output      logic signed [cbrf_pkg::XW-1:0]     root,
	output      logic        [cbrf_pkg::STEP_W-1:0] step_count,
	output      logic        [1:0]                  status
);
	import cbrf_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WAIT_A,
		S_WAIT_B,
		S_MID,
		S_WAIT_C,
		S_TEST
	} state_t;

	state_t                  state_q;
	feval_req_t              req_q;
	feval_rsp_t              rsp;

	// bracket: a_q is the low side (f <= 0 side), b_q the high side
	logic signed [XW-1:0]    a_q;
	logic signed [XW-1:0]    b_q;
	logic signed [XW-1:0]    c_q;
	logic [TOL_W-1:0]        tol_q;
	logic signed [FW-1:0]    fa_q;
	logic [FW-1:0]           fabs_q;
	logic [STEP_W-1:0]       steps_q;

	logic                    done_q;
	logic signed [XW-1:0]    root_q;
	logic [STEP_W-1:0]       step_count_q;
	logic [1:0]              status_q;

	logic                    fa_pos, fa_neg, f_pos, f_neg;
	logic [XW:0]             sum;
	logic signed [XW-1:0]    mid;
	logic [FW-1:0]           tol_w;

	cbrf_feval u_feval (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_q),
		.rsp    (rsp)
	);

	// strict signs of the stored f(a) and of the incoming value
	assign fa_neg = fa_q[FW-1];
	assign fa_pos = !fa_q[FW-1] && (fa_q != '0);
	assign f_neg  = rsp.f[FW-1];
	assign f_pos  = !rsp.f[FW-1] && (rsp.f != '0);

	// floor midpoint on the raw Q16.16 values
	assign sum = {a_q[XW-1], a_q} + {b_q[XW-1], b_q};
	assign mid = $signed(sum[XW:1]);

	// tolerance scaled to the 2^48 grid of f
	assign tol_w = {(FW - TOL_W - 32)'(0), tol_q, 32'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			req_q        <= '0;
			done_q       <= 1'b0;
			a_q          <= '0;
			b_q          <= '0;
			c_q          <= '0;
			tol_q        <= '0;
			fa_q         <= '0;
			fabs_q       <= '0;
			steps_q      <= '0;
			root_q       <= '0;
			step_count_q <= '0;
			status_q     <= STATUS_CONVERGED;
		end else begin
			req_q.go <= 1'b0;
			done_q   <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						a_q      <= first_guess;
						b_q      <= second_guess;
						tol_q    <= tolerance;
						steps_q  <= '0;
						c_q      <= '0;
						req_q.go <= 1'b1;
						req_q.x  <= first_guess;
						state_q  <= S_WAIT_A;
					end
				end
				S_WAIT_A: begin
					if (rsp.done) begin
						fa_q     <= rsp.f;
						req_q.go <= 1'b1;
						req_q.x  <= b_q;
						state_q  <= S_WAIT_B;
					end
				end
				S_WAIT_B: begin
					if (rsp.done) begin
						if ((fa_pos && f_pos) || (fa_neg && f_neg)) begin
							// no sign change across the bracket
							root_q       <= '0;
							step_count_q <= '0;
							status_q     <= STATUS_SAME_SIGN;
							done_q       <= 1'b1;
							state_q      <= S_IDLE;
						end else begin
							// order the ends so that f(a) <= f(b)
							if (fa_q > rsp.f) begin
								a_q <= b_q;
								b_q <= a_q;
							end
							state_q <= S_MID;
						end
					end
				end
				S_MID: begin
					c_q      <= mid;
					steps_q  <= steps_q + STEP_W'(1);
					req_q.go <= 1'b1;
					req_q.x  <= mid;
					state_q  <= S_WAIT_C;
				end
				S_WAIT_C: begin
					if (rsp.done) begin
						// an exact zero moves neither bound
						if (f_pos) begin
							b_q <= c_q;
						end else if (f_neg) begin
							a_q <= c_q;
						end
						fabs_q  <= f_neg ? (~rsp.f + FW'(1)) : rsp.f;
						state_q <= S_TEST;
					end
				end
				S_TEST: begin
					root_q       <= c_q;
					step_count_q <= steps_q;
					if (fabs_q <= tol_w) begin
						status_q <= STATUS_CONVERGED;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (steps_q == STEP_W'(MAX_STEPS)) begin
						status_q <= STATUS_STEP_CAP;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_MID;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign root       = root_q;
	assign step_count = step_count_q;
	assign status     = status_q;

endmodule
`default_nettype wire

FILE: design/cbrf_feval.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbrf_feval
// evaluates x^3 - 4x - 9 exactly in Q16.16 (result scaled by 2^48) with one
// shared 32x32 multiplier: square, low partial, high partial, then combine
// ----------------------------------------------------------------------------
module cbrf_feval (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cbrf_pkg::feval_req_t req,
	output      cbrf_pkg::feval_rsp_t rsp
);
	import cbrf_pkg::*;

	typedef enum logic [2:0] {
		E_IDLE,
		E_SQ,
		E_LO,
		E_HI,
		E_ADD,
		E_FIN
	} estate_t;

	estate_t       state_q;
	logic [XW-1:0] mag_q;
	logic          neg_q;
	logic [FW-1:0] off_q;
	logic [63:0]   mul_q;
	logic [31:0]   sqhi_q;
	logic [FW-1:0] acc_q;
	logic          done_q;

	logic [XW-1:0] x_u;
	logic [FW-1:0] lin;
	logic [31:0]   opa;
	logic [63:0]   prod;
	logic [FW-1:0] acc_sel;

	assign x_u = XW'(req.x);
	// x * 2^34, sign-extended to the full width
	assign lin = {{(FW - XW - 34){req.x[XW-1]}}, x_u, 34'b0};

	// shared multiplier, operand a chosen by step
	always_comb begin
		case (state_q)
			E_SQ:    opa = mag_q;
			E_LO:    opa = mul_q[31:0];
			default: opa = sqhi_q;
		endcase
	end
	assign prod = opa * mag_q;

	assign acc_sel = neg_q ? ~acc_q : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			done_q  <= 1'b0;
			mag_q   <= '0;
			neg_q   <= 1'b0;
			off_q   <= '0;
			mul_q   <= '0;
			sqhi_q  <= '0;
			acc_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				E_IDLE: begin
					if (req.go) begin
						mag_q   <= req.x[XW-1] ? (~x_u + XW'(1)) : x_u;
						neg_q   <= req.x[XW-1];
						// -(x * 2^34) - 9 * 2^48
						off_q   <= ~lin + OFF_K;
						state_q <= E_SQ;
					end
				end
				E_SQ: begin
					mul_q   <= prod;
					state_q <= E_LO;
				end
				E_LO: begin
					sqhi_q  <= mul_q[63:32];
					mul_q   <= prod;
					state_q <= E_HI;
				end
				E_HI: begin
					acc_q   <= {(FW - 64)'(0), mul_q};
					mul_q   <= prod;
					state_q <= E_ADD;
				end
				E_ADD: begin
					// cube magnitude = p0 + p1 * 2^32
					acc_q   <= acc_q + {mul_q, 32'b0};
					state_q <= E_FIN;
				end
				E_FIN: begin
					// signed cube plus the linear and constant terms
					acc_q   <= acc_sel + off_q + FW'(neg_q);
					done_q  <= 1'b1;
					state_q <= E_IDLE;
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.f    = $signed(acc_q);

endmodule
`default_nettype wire

FILE: design/cbrf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbrf_checker
// port-level checks on the root finder, attached to the top level by bind
// ----------------------------------------------------------------------------
module cbrf_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               start,
	input wire logic                               busy,
	input wire logic                               done,
	input wire logic signed [cbrf_pkg::XW-1:0]     root,
	input wire logic        [cbrf_pkg::STEP_W-1:0] step_count,
	input wire logic        [1:0]                  status
);
	import cbrf_pkg::*;

	// a taken word makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("word taken but block not busy");

	// the result strobe never comes two in a row
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// same-sign result carries no root and no steps
	a_same_sign: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STATUS_SAME_SIGN |-> root == '0 && step_count == '0)
		else $error("same-sign result with nonzero root or steps");

	// step cap only after the full step budget
	a_step_cap: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STATUS_STEP_CAP |-> step_count == STEP_W'(MAX_STEPS))
		else $error("step cap reported with wrong step count");

	// convergence needs at least one step and never more than the cap
	a_converged: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STATUS_CONVERGED |->
			step_count != '0 && step_count <= STEP_W'(MAX_STEPS))
		else $error("converged result with bad step count");

endmodule

bind cubic_bisection_root_finder_top cbrf_checker u_cbrf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.root       (root),
	.step_count (step_count),
	.status     (status)
);
`default_nettype wire
